// ===== sv/pur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pur_pkg: shared types and constants of the png row unfilter
// Sizes of the row store and pixel history, filter type codes, register
// indexes and the neighbour bundle passed to the predictor.
// ----------------------------------------------------------------------------
package pur_pkg;

    // sizes
    localparam int MAX_ROW_BYTES   = 4096;
    localparam int MAX_PIXEL_BYTES = 8;
    localparam int ADDR_W          = $clog2(MAX_ROW_BYTES);
    localparam int COL_W           = ADDR_W + 1;
    localparam int PIX_IDX_W       = $clog2(MAX_PIXEL_BYTES);
    localparam int PIX_W           = PIX_IDX_W + 1;

    // filter type codes
    localparam logic [7:0] FLT_NONE  = 8'd0;
    localparam logic [7:0] FLT_SUB   = 8'd1;
    localparam logic [7:0] FLT_UP    = 8'd2;
    localparam logic [7:0] FLT_AVG   = 8'd3;
    localparam logic [7:0] FLT_PAETH = 8'd4;
    localparam logic [7:0] BAD_FILTER_BYTE = 8'hFF;

    // register indexes, taken from paddr bit 2
    localparam logic REG_ROW_BYTES   = 1'b0;
    localparam logic REG_PIXEL_BYTES = 1'b1;

    // left, above and upper-left neighbours of one byte
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_nbr;

endpackage

// ===== sv/pur_row_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pur_row_store: previous-row byte store
// Synchronous memory with one read and one write port, a fill count that
// makes never-written columns read as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module pur_row_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [pur_pkg::ADDR_W-1:0] i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [pur_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]                i_wr_data,
    output logic [7:0]                o_rd_data
);

    logic [7:0]                r_mem [pur_pkg::MAX_ROW_BYTES];
    logic [7:0]                r_mem_q;
    logic [7:0]                r_fwd_data;
    logic                      r_hit;
    logic                      r_rd_vld;
    logic [pur_pkg::COL_W-1:0] r_fill;
    logic [pur_pkg::COL_W-1:0] n_fill;
    logic [pur_pkg::COL_W-1:0] wr_end;

    // columns are written in order from zero, so the written set is a prefix
    assign wr_end = {1'b0, i_wr_addr} + pur_pkg::COL_W'(1);
    assign n_fill = (i_wr_en && (wr_end > r_fill)) ? wr_end : r_fill;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_mem_q    <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // fill count and read qualifiers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_hit    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_rd_en) begin
                r_hit    <= i_wr_en && (i_wr_addr == i_rd_addr);
                r_rd_vld <= {1'b0, i_rd_addr} < r_fill;
            end
        end
    end

    // unwritten columns read as zero, same-edge write wins
    assign o_rd_data = r_hit ? r_fwd_data : (r_rd_vld ? r_mem_q : 8'd0);

endmodule

// ===== sv/pur_predict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pur_predict: filter reconstruction of one byte
// None, Sub, Up, Average and full-precision Paeth; unknown types give 0xff.
// ----------------------------------------------------------------------------
module pur_predict (
    input  logic [7:0]    i_filter,
    input  logic [7:0]    i_x,
    input  pur_pkg::t_nbr i_nbr,
    output logic [7:0]    o_byte
);

    logic [8:0]         avg_sum;
    logic signed [10:0] d_a;
    logic signed [10:0] d_b;
    logic signed [10:0] d_c;
    logic [10:0]        p_a;
    logic [10:0]        p_b;
    logic [10:0]        p_c;
    logic [7:0]         paeth;

    // paeth distances
    always_comb begin
        d_a = $signed({3'b000, i_nbr.b}) - $signed({3'b000, i_nbr.c});
        d_b = $signed({3'b000, i_nbr.a}) - $signed({3'b000, i_nbr.c});
        d_c = d_a + d_b;
        p_a = d_a[10] ? 11'(-d_a) : 11'(d_a);
        p_b = d_b[10] ? 11'(-d_b) : 11'(d_b);
        p_c = d_c[10] ? 11'(-d_c) : 11'(d_c);
        if ((p_a <= p_b) && (p_a <= p_c)) begin
            paeth = i_nbr.a;
        end else if (p_b <= p_c) begin
            paeth = i_nbr.b;
        end else begin
            paeth = i_nbr.c;
        end
    end

    assign avg_sum = {1'b0, i_nbr.a} + {1'b0, i_nbr.b};

    // filter select
    always_comb begin
        case (i_filter)
            pur_pkg::FLT_NONE:  o_byte = i_x;
            pur_pkg::FLT_SUB:   o_byte = i_x + i_nbr.a;
            pur_pkg::FLT_UP:    o_byte = i_x + i_nbr.b;
            pur_pkg::FLT_AVG:   o_byte = i_x + avg_sum[8:1];
            pur_pkg::FLT_PAETH: o_byte = i_x + paeth;
            default:            o_byte = pur_pkg::BAD_FILTER_BYTE;
        endcase
    end

endmodule

// ===== sv/png_row_unfilter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter: PNG scanline filter reconstruction
// Byte stream in, reconstructed image bytes out, APB register port.
// ----------------------------------------------------------------------------
// The s_axis channel carries the inflated image stream, one byte per
// transfer. The first byte of every row is its filter type and gives no
// output; each of the next row_bytes bytes gives one m_axis transfer with the
// reconstructed byte, tlast marking the final byte of the row.
// Registers (APB): row_bytes at 0x0, pixel_bytes at 0x4.
// Throughput is one byte per cycle while m_axis does not stall, set by the
// single read and single write port of the previous-row memory. A data byte
// is read from the memory at the edge it is taken and held in stage 1; it is
// reconstructed and written back when stage 1 advances, entering the output
// register at that edge. Filter bytes are taken without waiting.
// The left neighbour comes from a pixel history fed by the bytes just made.
// Reset empties the pipeline and starts with a filter byte; the row store
// reads as zero through a fill count, so no clearing pass is needed.
// When m_axis stalls, the output register and the byte in stage 1 are held, and
// with stage 1 full s_axis takes filter bytes only until the output moves again.
// ----------------------------------------------------------------------------
module png_row_unfilter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // row_last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W     = pur_pkg::COL_W;
    localparam int ADDR_W    = pur_pkg::ADDR_W;
    localparam int PIX_W     = pur_pkg::PIX_W;
    localparam int PIX_IDX_W = pur_pkg::PIX_IDX_W;

    logic [COL_W-1:0]     r_row_bytes;
    logic [PIX_W-1:0]     r_pixel_bytes;
    logic [COL_W-1:0]     r_col;
    logic [7:0]           r_filter;

    logic                 r_s1_vld;
    logic [7:0]           r_s1_x;
    logic [7:0]           r_s1_filter;
    logic [ADDR_W-1:0]    r_s1_addr;
    logic                 r_s1_first;
    logic                 r_s1_last;

    logic [7:0]           r_left [pur_pkg::MAX_PIXEL_BYTES];
    logic [7:0]           r_upleft [pur_pkg::MAX_PIXEL_BYTES];

    logic                 r_out_vld;
    logic [7:0]           r_out_data;
    logic                 r_out_last;

    logic [COL_W-1:0]     len_eff;
    logic [PIX_W-1:0]     pix_eff;
    logic [PIX_IDX_W-1:0] pix_idx;
    logic [COL_W-1:0]     n_col;
    logic                 is_filter;
    logic                 in_xfer;
    logic                 data_xfer;
    logic                 adv;
    logic                 cfg_wr;
    logic [7:0]           b_byte;
    logic [7:0]           r_byte;
    pur_pkg::t_nbr        nbr;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes   <= COL_W'(pur_pkg::MAX_ROW_BYTES);
            r_pixel_bytes <= PIX_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == pur_pkg::REG_ROW_BYTES) begin
                r_row_bytes <= pwdata[COL_W-1:0];
            end else begin
                r_pixel_bytes <= pwdata[PIX_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == pur_pkg::REG_ROW_BYTES) begin
            prdata = {{(32-COL_W){1'b0}}, r_row_bytes};
        end else begin
            prdata = {{(32-PIX_W){1'b0}}, r_pixel_bytes};
        end
    end

    // effective row length and pixel size, out-of-range values clamped
    always_comb begin
        if (r_row_bytes == '0) begin
            len_eff = COL_W'(1);
        end else if (r_row_bytes > COL_W'(pur_pkg::MAX_ROW_BYTES)) begin
            len_eff = COL_W'(pur_pkg::MAX_ROW_BYTES);
        end else begin
            len_eff = r_row_bytes;
        end
        if (r_pixel_bytes == '0) begin
            pix_eff = PIX_W'(1);
        end else if (r_pixel_bytes > PIX_W'(pur_pkg::MAX_PIXEL_BYTES)) begin
            pix_eff = PIX_W'(pur_pkg::MAX_PIXEL_BYTES);
        end else begin
            pix_eff = r_pixel_bytes;
        end
    end

    assign pix_idx = PIX_IDX_W'(pix_eff - PIX_W'(1));

    // input handshake: filter bytes never wait, data bytes need stage 1
    assign is_filter     = r_col >= len_eff;
    assign adv           = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = is_filter || !r_s1_vld || adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign data_xfer     = in_xfer && !is_filter;
    assign n_col         = r_col + COL_W'(1);

    // column counter and row filter type
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= COL_W'(pur_pkg::MAX_ROW_BYTES);
            r_filter <= pur_pkg::FLT_NONE;
        end else if (in_xfer) begin
            if (is_filter) begin
                r_filter <= s_axis_tdata;
                r_col    <= '0;
            end else begin
                r_col <= n_col;
            end
        end
    end

    // stage 1: byte waiting for its above neighbour from the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (data_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_xfer) begin
            r_s1_x      <= s_axis_tdata;
            r_s1_filter <= r_filter;
            r_s1_addr   <= r_col[ADDR_W-1:0];
            r_s1_first  <= r_col < {{(COL_W-PIX_W){1'b0}}, pix_eff};
            r_s1_last   <= n_col >= len_eff;
        end
    end

    // previous-row store, read on transfer and written back on advance
    pur_row_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (data_xfer),
        .i_rd_addr (r_col[ADDR_W-1:0]),
        .i_wr_en   (adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_byte),
        .o_rd_data (b_byte)
    );

    // neighbours; a and c are zero within the first pixel of the row
    always_comb begin
        nbr.b = b_byte;
        nbr.a = r_s1_first ? 8'd0 : r_left[pix_idx];
        nbr.c = r_s1_first ? 8'd0 : r_upleft[pix_idx];
    end

    pur_predict u_predict (
        .i_filter (r_s1_filter),
        .i_x      (r_s1_x),
        .i_nbr    (nbr),
        .o_byte   (r_byte)
    );

    // pixel history of made bytes and above bytes
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = pur_pkg::MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                r_left[i]   <= r_left[i-1];
                r_upleft[i] <= r_upleft[i-1];
            end
            r_left[0]   <= r_byte;
            r_upleft[0] <= b_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= r_byte;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sv/pur_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pur_chk: port checker for the png row unfilter
// Watches the stream and register ports and flags behaviour over time.
// ----------------------------------------------------------------------------
module pur_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       pready
);

    // no output transfer is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // a fresh output traces back to an input transfer through stage 1 and the output register
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output without matching input transfer");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind png_row_unfilter pur_chk u_pur_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
